// File: design/ome_pkg.sv
// ----------------------------------------------------------------------------
// ome_pkg
// Shared types, constants and the step program for the outer/middle ear
// filter chain: state RAM map, operand selects and the per-cycle control word.
// ----------------------------------------------------------------------------
package ome_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF   = 32;

  // Configuration port
  localparam int NUM_REGS   = 8;
  localparam int REG_AW     = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int HALF_W     = 32;

  // Coefficient halves, two per register
  localparam int NUM_COEF = 16;
  localparam int COEF_AW  = 4;

  // State RAM: two slots per history pair, one for the last displacement
  localparam int STATE_DEPTH = 14;
  localparam int STATE_AW    = 4;

  localparam int IO_WIDTH = 32;

  // Step program
  localparam int NUM_STEPS = 33;
  localparam int STEP_W    = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef enum logic [2:0] {
    SLOT_CONCHA_IN  = 3'd0,
    SLOT_CONCHA_OUT = 3'd1,
    SLOT_CANAL_IN   = 3'd2,
    SLOT_CANAL_OUT  = 3'd3,
    SLOT_STAPES_IN  = 3'd4,
    SLOT_STAPES_VEL = 3'd5,
    SLOT_LAST_DISP  = 3'd6
  } slot_t;

  // HIST_PREV is one sample back, HIST_OLDER two back (and the slot rewritten)
  typedef enum logic {
    HIST_PREV  = 1'b0,
    HIST_OLDER = 1'b1
  } hist_t;

  typedef enum logic [1:0] {
    A_RD = 2'd0,
    A_DX = 2'd1,
    A_DE = 2'd2,
    A_T  = 2'd3
  } a_sel_t;

  typedef enum logic [4:0] {
    C_CONCHA_J = 5'd0,
    C_CONCHA_K = 5'd1,
    C_CONCHA_L = 5'd2,
    C_CONCHA_G = 5'd3,
    C_CANAL_J  = 5'd4,
    C_CANAL_K  = 5'd5,
    C_CANAL_L  = 5'd6,
    C_CANAL_G  = 5'd7,
    C_B0       = 5'd8,
    C_B1       = 5'd9,
    C_B2       = 5'd10,
    C_A0       = 5'd11,
    C_A1       = 5'd12,
    C_A2       = 5'd13,
    C_REFLEX   = 5'd14,
    C_LP_P     = 5'd15,
    C_LP_GAIN  = 5'd16
  } c_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_SET  = 3'd1,
    ACC_SETN = 3'd2,
    ACC_ADD  = 3'd3,
    ACC_SUB  = 3'd4,
    ACC_SETX = 3'd5,
    ACC_SETE = 3'd6
  } acc_op_t;

  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_T    = 2'd1,
    SAT_E    = 2'd2
  } sat_dst_t;

  typedef enum logic [1:0] {
    WS_X = 2'd0,
    WS_E = 2'd1,
    WS_T = 2'd2
  } wr_src_t;

  typedef struct packed {
    logic     rd_en;
    slot_t    rd_slot;
    hist_t    rd_hist;
    logic     mul_en;
    a_sel_t   a_sel;
    c_sel_t   c_sel;
    acc_op_t  acc_op;
    sat_dst_t sat_dst;
    logic     wr_en;
    slot_t    wr_slot;
    wr_src_t  wr_src;
  } uop_t;

  localparam uop_t UOP_NOP = '{
    rd_en:   1'b0,
    rd_slot: SLOT_CONCHA_IN,
    rd_hist: HIST_PREV,
    mul_en:  1'b0,
    a_sel:   A_RD,
    c_sel:   C_CONCHA_J,
    acc_op:  ACC_NONE,
    sat_dst: SAT_NONE,
    wr_en:   1'b0,
    wr_slot: SLOT_CONCHA_IN,
    wr_src:  WS_X
  };

  // Per-cycle control. A read issued in one step returns in the next, a
  // product made in one step is accumulated in the next, and an accumulator
  // finished in one step is saturated into a working register in the next.
  function automatic uop_t ucode(input logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_NOP;
    unique case (step)
      // concha band-pass
      6'd0: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_CONCHA_IN; u.rd_hist = HIST_OLDER;
      end
      6'd1: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_CONCHA_OUT; u.rd_hist = HIST_PREV;
        u.mul_en = 1'b1; u.a_sel = A_DX; u.c_sel = C_CONCHA_J;
      end
      6'd2: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_CONCHA_OUT; u.rd_hist = HIST_OLDER;
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_CONCHA_K;
        u.acc_op = ACC_SET;
      end
      6'd3: begin
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_CONCHA_L;
        u.acc_op = ACC_ADD;
        u.wr_en = 1'b1; u.wr_slot = SLOT_CONCHA_IN; u.wr_src = WS_X;
      end
      6'd4: u.acc_op = ACC_ADD;
      6'd5: u.sat_dst = SAT_T;
      6'd6: begin
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_CONCHA_G;
        u.wr_en = 1'b1; u.wr_slot = SLOT_CONCHA_OUT; u.wr_src = WS_T;
      end
      6'd7: u.acc_op = ACC_SETX;
      // ear canal band-pass
      6'd8: begin
        u.sat_dst = SAT_E;
        u.rd_en = 1'b1; u.rd_slot = SLOT_CANAL_IN; u.rd_hist = HIST_OLDER;
      end
      6'd9: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_CANAL_OUT; u.rd_hist = HIST_PREV;
        u.mul_en = 1'b1; u.a_sel = A_DE; u.c_sel = C_CANAL_J;
      end
      6'd10: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_CANAL_OUT; u.rd_hist = HIST_OLDER;
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_CANAL_K;
        u.acc_op = ACC_SET;
        u.wr_en = 1'b1; u.wr_slot = SLOT_CANAL_IN; u.wr_src = WS_E;
      end
      6'd11: begin
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_CANAL_L;
        u.acc_op = ACC_ADD;
      end
      6'd12: u.acc_op = ACC_ADD;
      6'd13: u.sat_dst = SAT_T;
      6'd14: begin
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_CANAL_G;
        u.wr_en = 1'b1; u.wr_slot = SLOT_CANAL_OUT; u.wr_src = WS_T;
      end
      6'd15: u.acc_op = ACC_SETE;
      // acoustic reflex
      6'd16: u.sat_dst = SAT_T;
      6'd17: begin
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_REFLEX;
      end
      6'd18: u.acc_op = ACC_SET;
      // stapes high-pass, feedforward part
      6'd19: u.sat_dst = SAT_T;
      6'd20: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_STAPES_IN; u.rd_hist = HIST_PREV;
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_B0;
      end
      6'd21: begin
        u.rd_en = 1'b1; u.rd_slot = SLOT_STAPES_IN; u.rd_hist = HIST_OLDER;
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_B1;
        u.acc_op = ACC_SET;
      end
      6'd22: begin
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_B2;
        u.acc_op = ACC_ADD;
      end
      6'd23: begin
        u.acc_op = ACC_ADD;
        u.rd_en = 1'b1; u.rd_slot = SLOT_STAPES_VEL; u.rd_hist = HIST_PREV;
        u.wr_en = 1'b1; u.wr_slot = SLOT_STAPES_IN; u.wr_src = WS_T;
      end
      // stapes high-pass, feedback part
      6'd24: begin
        u.sat_dst = SAT_T;
        u.rd_en = 1'b1; u.rd_slot = SLOT_STAPES_VEL; u.rd_hist = HIST_OLDER;
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_A1;
      end
      6'd25: begin
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_A2;
        u.acc_op = ACC_SETN;
      end
      6'd26: begin
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_A0;
        u.acc_op = ACC_SUB;
      end
      6'd27: begin
        u.acc_op = ACC_ADD;
        u.rd_en = 1'b1; u.rd_slot = SLOT_LAST_DISP; u.rd_hist = HIST_PREV;
      end
      // first-order low-pass
      6'd28: begin
        u.sat_dst = SAT_T;
        u.mul_en = 1'b1; u.a_sel = A_RD; u.c_sel = C_LP_P;
      end
      6'd29: begin
        u.mul_en = 1'b1; u.a_sel = A_T; u.c_sel = C_LP_GAIN;
        u.acc_op = ACC_SETN;
        u.wr_en = 1'b1; u.wr_slot = SLOT_STAPES_VEL; u.wr_src = WS_T;
      end
      6'd30: u.acc_op = ACC_ADD;
      6'd31: u.sat_dst = SAT_T;
      6'd32: begin
        u.wr_en = 1'b1; u.wr_slot = SLOT_LAST_DISP; u.wr_src = WS_T;
      end
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

endpackage

// File: design/outer_middle_ear_filter_chain_top.sv
// ----------------------------------------------------------------------------
// outer_middle_ear_filter_chain_top
// Sound pressure in, stapes displacement out, through concha and ear canal
// band-passes, reflex scale, stapes high-pass and a first-order low-pass.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                        Beat accepted when
//   input     in_valid, in_stall, in_pressure_sample       in_valid & !in_stall
//   result    out_valid, out_stall, out_stapes_displacement out_valid & !out_stall
//   config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// Each item runs through the step program, paced by the single shared
// multiplier (17 products per item) and the one-read-port state RAM.
// The result waits in an output register; the next input beat is taken while
// it waits, and the last step holds only if that register is still full.
// Reset clears the history valid bits, so every history reads as zero until
// rewritten; there is no clearing pass.
module outer_middle_ear_filter_chain_top #(
  parameter int SAMPLE_WIDTH = ome_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = ome_pkg::COEF_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ome_pkg::IO_WIDTH-1:0]       in_pressure_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ome_pkg::IO_WIDTH-1:0]       out_stapes_displacement,
  input  logic                               cfg_we,
  input  logic [ome_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ome_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [COEF_WIDTH:0] LPG_ONE = (COEF_WIDTH + 1)'(1) << (COEF_WIDTH - 4);
  localparam logic [ome_pkg::COEF_AW-1:0] LP_P_IDX = ome_pkg::COEF_AW'(ome_pkg::C_LP_P);

  ome_pkg::state_t state_r, state_nxt;
  logic [ome_pkg::STEP_W-1:0] step_r, step_nxt;
  logic phase_r;
  logic out_valid_r, out_valid_nxt;
  logic [ome_pkg::IO_WIDTH-1:0] out_data_r;
  logic [ome_pkg::STATE_DEPTH-1:0] valid_r;
  logic rd_vld_r;

  logic [COEF_WIDTH-1:0] coef_r [ome_pkg::NUM_COEF];
  logic signed [COEF_WIDTH:0] lpg_r;
  logic signed [COEF_WIDTH:0] coef_op;
  logic [ome_pkg::COEF_AW-1:0] coef_idx;
  logic [ome_pkg::REG_AW-1:0] reg_idx;

  ome_pkg::uop_t uop;
  logic in_take;
  logic last_step;
  logic out_free;
  logic finish;

  logic [ome_pkg::STATE_AW-1:0] rd_addr;
  logic [ome_pkg::STATE_AW-1:0] wr_addr;
  logic [SAMPLE_WIDTH-1:0] ram_q;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [SAMPLE_WIDTH-1:0] wr_data;
  logic [SAMPLE_WIDTH-1:0] result;

  // Configuration registers, two coefficient halves each
  assign reg_idx = cfg_index[ome_pkg::REG_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ome_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < ome_pkg::CFG_IDX_W'(ome_pkg::NUM_REGS))) begin
      coef_r[{reg_idx, 1'b0}] <= cfg_data[COEF_WIDTH-1:0];
      coef_r[{reg_idx, 1'b1}] <= cfg_data[ome_pkg::HALF_W+COEF_WIDTH-1:ome_pkg::HALF_W];
    end
  end

  // low-pass gain 1 + p, formed ahead in a register
  always_ff @(posedge clk) begin
    lpg_r <= $signed({coef_r[LP_P_IDX][COEF_WIDTH-1],
                      coef_r[LP_P_IDX]}) + $signed(LPG_ONE);
  end

  // Sequencer
  assign uop       = (state_r == ome_pkg::ST_RUN) ? ome_pkg::ucode(step_r) : ome_pkg::UOP_NOP;
  assign in_take   = in_valid && (state_r == ome_pkg::ST_IDLE);
  assign last_step = (step_r == ome_pkg::LAST_STEP);
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ome_pkg::ST_RUN) && last_step && out_free;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ome_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = ome_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      ome_pkg::ST_RUN: begin
        if (!last_step) begin
          step_nxt = step_r + 1'b1;
        end else if (out_free) begin
          state_nxt = ome_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ome_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ome_pkg::ST_IDLE;
      step_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        phase_r <= ~phase_r;
      end
      if (uop.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= ome_pkg::IO_WIDTH'($signed(result));
    end
    if (uop.rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // State RAM addressing: the slot at phase holds the older sample and takes
  // the new one; the displacement register sits in slot zero of its pair
  always_comb begin
    if (uop.rd_slot == ome_pkg::SLOT_LAST_DISP) begin
      rd_addr = {uop.rd_slot, 1'b0};
    end else if (uop.rd_hist == ome_pkg::HIST_OLDER) begin
      rd_addr = {uop.rd_slot, phase_r};
    end else begin
      rd_addr = {uop.rd_slot, ~phase_r};
    end
    if (uop.wr_slot == ome_pkg::SLOT_LAST_DISP) begin
      wr_addr = {uop.wr_slot, 1'b0};
    end else begin
      wr_addr = {uop.wr_slot, phase_r};
    end
  end

  ome_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (ome_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (uop.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (uop.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // never-written history reads as zero
  assign rd_data = rd_vld_r ? ram_q : '0;

  always_comb begin
    coef_idx = uop.c_sel[ome_pkg::COEF_AW-1:0];
    if (uop.c_sel == ome_pkg::C_LP_GAIN) begin
      coef_op = lpg_r;
    end else begin
      coef_op = $signed({coef_r[coef_idx][COEF_WIDTH-1], coef_r[coef_idx]});
    end
  end

  ome_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk     (clk),
    .x_load  (in_take),
    .x_in    (in_pressure_sample[SAMPLE_WIDTH-1:0]),
    .uop     (uop),
    .rd_data (rd_data),
    .coef_op (coef_op),
    .wr_data (wr_data),
    .result  (result)
  );

  assign in_stall                = (state_r != ome_pkg::ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_stapes_displacement = out_data_r;

endmodule

// File: design/ome_ram.sv
// ----------------------------------------------------------------------------
// ome_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ome_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/ome_mac.sv
// ----------------------------------------------------------------------------
// ome_mac
// Shared multiply-accumulate datapath: operand select, one signed multiplier,
// round-half-up rescale, accumulator, saturation and the working registers.
// ----------------------------------------------------------------------------
module ome_mac #(
  parameter int SAMPLE_WIDTH = ome_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = ome_pkg::COEF_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    x_load,
  input  logic [SAMPLE_WIDTH-1:0] x_in,
  input  ome_pkg::uop_t           uop,
  input  logic [SAMPLE_WIDTH-1:0] rd_data,
  input  logic signed [COEF_WIDTH:0] coef_op,
  output logic [SAMPLE_WIDTH-1:0] wr_data,
  output logic [SAMPLE_WIDTH-1:0] result
);

  localparam int G     = COEF_WIDTH - 4;
  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH + 2;
  localparam int ACC_W = SAMPLE_WIDTH + 8;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (G - 1);
  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SAMPLE_WIDTH-1:0] x_r;
  logic [SAMPLE_WIDTH-1:0] e_r;
  logic [SAMPLE_WIDTH-1:0] t_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic signed [SAMPLE_WIDTH:0] rd_ext;
  logic signed [SAMPLE_WIDTH:0] a_op;
  logic signed [PW-1:0]         rnd_full;
  logic signed [PW-1:0]         rnd_sh;
  logic signed [ACC_W-1:0]      rnd;
  logic signed [ACC_W-1:0]      x_ext;
  logic signed [ACC_W-1:0]      e_ext;
  logic [ACC_W-SAMPLE_WIDTH:0]  acc_top;
  logic                         acc_ovf;
  logic [SAMPLE_WIDTH-1:0]      sat_val;

  always_comb begin
    rd_ext = {rd_data[SAMPLE_WIDTH-1], rd_data};
    case (uop.a_sel)
      ome_pkg::A_RD: a_op = rd_ext;
      ome_pkg::A_DX: a_op = $signed({x_r[SAMPLE_WIDTH-1], x_r}) - rd_ext;
      ome_pkg::A_DE: a_op = $signed({e_r[SAMPLE_WIDTH-1], e_r}) - rd_ext;
      ome_pkg::A_T:  a_op = $signed({t_r[SAMPLE_WIDTH-1], t_r});
      default:       a_op = rd_ext;
    endcase
    prod_nxt = a_op * coef_op;
  end

  // floor((p + half) / 2^G)
  always_comb begin
    rnd_full = prod_r + HALF;
    rnd_sh   = rnd_full >>> G;
    rnd      = rnd_sh[ACC_W-1:0];
    x_ext    = ACC_W'($signed(x_r));
    e_ext    = ACC_W'($signed(e_r));
    case (uop.acc_op)
      ome_pkg::ACC_SET:  acc_nxt = rnd;
      ome_pkg::ACC_SETN: acc_nxt = -rnd;
      ome_pkg::ACC_ADD:  acc_nxt = acc_r + rnd;
      ome_pkg::ACC_SUB:  acc_nxt = acc_r - rnd;
      ome_pkg::ACC_SETX: acc_nxt = x_ext + rnd;
      ome_pkg::ACC_SETE: acc_nxt = e_ext + rnd;
      default:           acc_nxt = acc_r;
    endcase
  end

  // saturate to the signed sample range
  always_comb begin
    acc_top = acc_r[ACC_W-1:SAMPLE_WIDTH-1];
    acc_ovf = !((&acc_top) || !(|acc_top));
    if (acc_ovf) begin
      sat_val = acc_r[ACC_W-1] ? SMIN : SMAX;
    end else begin
      sat_val = acc_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (x_load) begin
      x_r <= x_in;
    end
    if (uop.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (uop.sat_dst == ome_pkg::SAT_T) begin
      t_r <= sat_val;
    end
    if (uop.sat_dst == ome_pkg::SAT_E) begin
      e_r <= sat_val;
    end
  end

  always_comb begin
    case (uop.wr_src)
      ome_pkg::WS_X: wr_data = x_r;
      ome_pkg::WS_E: wr_data = e_r;
      ome_pkg::WS_T: wr_data = t_r;
      default:       wr_data = t_r;
    endcase
  end

  assign result = t_r;

endmodule
